// ===== design/rotated_packed_pixel_plotter_defines.svh =====
`ifndef ROTATED_PACKED_PIXEL_PLOTTER_DEFINES_SVH
`define ROTATED_PACKED_PIXEL_PLOTTER_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define RPPP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rppp: same-cycle check failed");

// next-cycle implication
`define RPPP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rppp: next-cycle check failed");

`endif

// ===== design/rppp_pkg.sv =====
package rppp_pkg;

  // default sizes
  localparam int STORE_BYTES_DEF = 262144;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 512;

  // register port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_ROTATION = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_HEIGHT   = 2'd2;
  localparam logic [1:0] REG_FORMAT   = 2'd3;

  localparam logic [1:0]  ROTATION_RST = 2'd0;
  localparam logic [10:0] WIDTH_RST    = 11'd640;
  localparam logic [9:0]  HEIGHT_RST   = 10'd384;
  localparam logic        FORMAT_RST   = 1'b0;

  // pixel formats
  localparam logic FMT_BIT = 1'b0;
  localparam logic FMT_NIB = 1'b1;

  // rotations
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // request functions
  localparam logic [1:0] FN_ROT_DRAW = 2'd0;
  localparam logic [1:0] FN_ABS_DRAW = 2'd1;
  localparam logic [1:0] FN_ABS_READ = 2'd2;

  // colours
  localparam logic [1:0] COL_BLACK = 2'd0;
  localparam logic [1:0] COL_WHITE = 2'd1;
  localparam logic [1:0] COL_RED   = 2'd2;

  // nibble codes and byte masks
  localparam logic [3:0] NIB_BLACK   = 4'b0000;
  localparam logic [3:0] NIB_WHITE   = 4'b0011;
  localparam logic [3:0] NIB_RED     = 4'b0100;
  localparam logic [3:0] NIB_MASK    = 4'b1111;
  localparam logic [7:0] BIT_MSB     = 8'h80;
  localparam logic [7:0] NIB_HI_MASK = 8'hF0;

  typedef struct packed {
    logic [1:0]        func;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [1:0]        color;
  } in_req_t;

  typedef struct packed {
    logic [1:0] read_color;
    logic       in_range;
  } out_res_t;

  // per-request control handed from the mapper to the store sequencer
  typedef struct packed {
    logic       ok;
    logic       draw;
    logic       rd;
    logic [1:0] color;
  } job_ctl_t;

endpackage

// ===== design/rppp_store.sv =====
module rppp_store #(
  parameter int DEPTH = rppp_pkg::STORE_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          re,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/rppp_map.sv =====
module rppp_map #(
  parameter int WW = 11,
  parameter int HW = 10,
  parameter int LW = WW + HW
) (
  input  logic               clk,
  input  logic               load,
  input  logic               calc,
  input  rppp_pkg::in_req_t  req,
  input  logic [1:0]         rotation,
  input  logic [WW-1:0]      w_eff,
  input  logic [HW-1:0]      h_eff,
  output logic [LW-1:0]      lin,
  output rppp_pkg::job_ctl_t ctl
);

  rppp_pkg::in_req_t  req_r;
  logic [LW-1:0]      lin_r;
  rppp_pkg::job_ctl_t ctl_r;

  logic        rot_draw;
  logic        swap;
  logic        access;
  logic        in_panel;
  logic [15:0] bx;
  logic [15:0] by;
  logic [1:0]  rot_sel;
  logic [WW-1:0] ax;
  logic [HW-1:0] ay;
  logic [LW-1:0] lin_nxt;
  rppp_pkg::job_ctl_t ctl_nxt;

  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= req;
    end
  end

  always_comb begin
    rot_draw = (req_r.func == rppp_pkg::FN_ROT_DRAW);
    swap     = rot_draw && rotation[0];
    access   = rot_draw || (req_r.func == rppp_pkg::FN_ABS_DRAW) ||
               (req_r.func == rppp_pkg::FN_ABS_READ);
    bx       = swap ? 16'(h_eff) : 16'(w_eff);
    by       = swap ? 16'(w_eff) : 16'(h_eff);
    in_panel = !req_r.x_coord[15] && !req_r.y_coord[15] &&
               ({1'b0, req_r.x_coord[14:0]} < bx) &&
               ({1'b0, req_r.y_coord[14:0]} < by);
    rot_sel  = rot_draw ? rotation : rppp_pkg::ROT_0;

    // coordinates only meaningful when inside, so truncation is safe
    case (rot_sel)
      rppp_pkg::ROT_90: begin
        ax = w_eff - WW'(1) - WW'(req_r.y_coord);
        ay = HW'(req_r.x_coord);
      end
      rppp_pkg::ROT_180: begin
        ax = w_eff - WW'(1) - WW'(req_r.x_coord);
        ay = h_eff - HW'(1) - HW'(req_r.y_coord);
      end
      rppp_pkg::ROT_270: begin
        ax = WW'(req_r.y_coord);
        ay = h_eff - HW'(1) - HW'(req_r.x_coord);
      end
      default: begin
        ax = WW'(req_r.x_coord);
        ay = HW'(req_r.y_coord);
      end
    endcase

    lin_nxt       = LW'(ax) + LW'(ay) * LW'(w_eff);
    ctl_nxt.ok    = in_panel && access;
    ctl_nxt.draw  = (req_r.func != rppp_pkg::FN_ABS_READ);
    ctl_nxt.rd    = (req_r.func == rppp_pkg::FN_ABS_READ);
    ctl_nxt.color = req_r.color;
  end

  always_ff @(posedge clk) begin
    if (calc) begin
      lin_r <= lin_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign lin = lin_r;
  assign ctl = ctl_r;

endmodule

// ===== design/rotated_packed_pixel_plotter.sv =====
// channel  | handshake               | payload
// ---------+-------------------------+-------------------------------------
// in       | in_valid / in_stall     | in_data  (func, x_coord, y_coord, color)
// out      | out_valid / out_stall   | out_data (read_color, in_range)
// cfg      | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied high)
//
// each request passes map and multiply, store read, then modify and write back; a new request
// may be taken as the previous one writes back; the single-port byte store keeps read and
// write-back in separate states; the result is registered; a held result stalls the
// write-back stage, and with it the input side, only once the next result is ready
// rst_n is synchronous; the frame store is not cleared and must be written first

`include "rotated_packed_pixel_plotter_defines.svh"

module rotated_packed_pixel_plotter #(
  parameter int STORE_BYTES = rppp_pkg::STORE_BYTES_DEF,
  parameter int MAX_WIDTH   = rppp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = rppp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rppp_pkg::in_req_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rppp_pkg::out_res_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rppp_pkg::CFG_AW-1:0] paddr,
  input  logic [rppp_pkg::CFG_DW-1:0] pwdata,
  output logic [rppp_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int LW = WW + HW;
  localparam int AW = $clog2(STORE_BYTES);

  // one-hot sequencer
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_READ = 4'b0100,
    ST_MOD  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // configuration registers
  logic [1:0]  rotation_r;
  logic [10:0] width_r;
  logic [9:0]  height_r;
  logic        format_r;
  logic        cfg_wr;

  // effective panel size
  logic [11:0]   w_round;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  // handshakes
  logic in_accept;
  logic can_load;

  // mapper outputs
  logic [LW-1:0]      lin;
  rppp_pkg::job_ctl_t ctl;

  // store access
  logic [LW-1:0] byte_addr;
  logic          hit;
  logic          mem_re;
  logic          mem_we;
  logic [7:0]    rdata;
  logic [7:0]    wdata;

  // pixel modify and read-back
  logic [7:0] bit_mask;
  logic       nib_hi;
  logic [3:0] code;
  logic [3:0] nib;
  logic [1:0] pix_color;

  // output register
  logic               out_valid_r;
  rppp_pkg::out_res_t out_data_r;
  rppp_pkg::out_res_t res_nxt;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= rppp_pkg::ROTATION_RST;
      width_r    <= rppp_pkg::WIDTH_RST;
      height_r   <= rppp_pkg::HEIGHT_RST;
      format_r   <= rppp_pkg::FORMAT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rppp_pkg::REG_ROTATION: rotation_r <= pwdata[1:0];
        rppp_pkg::REG_WIDTH:    width_r    <= pwdata[10:0];
        rppp_pkg::REG_HEIGHT:   height_r   <= pwdata[9:0];
        rppp_pkg::REG_FORMAT:   format_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rppp_pkg::REG_ROTATION: prdata = rppp_pkg::CFG_DW'(rotation_r);
      rppp_pkg::REG_WIDTH:    prdata = rppp_pkg::CFG_DW'(width_r);
      rppp_pkg::REG_HEIGHT:   prdata = rppp_pkg::CFG_DW'(height_r);
      rppp_pkg::REG_FORMAT:   prdata = rppp_pkg::CFG_DW'(format_r);
      default:                prdata = '0;
    endcase
  end

  // width rounded up to whole bytes of one-bit pixels, both sides saturated
  assign w_round = ({1'b0, width_r} + 12'd7) & ~12'd7;
  assign w_eff   = (32'(w_round) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_round);
  assign h_eff   = (32'(height_r) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_r);

  // ---------------------------------------------------------------- sequencer
  // the output register may take a result when it is empty or being drained
  assign can_load  = !out_valid_r || !out_stall;
  // a new request enters while idle or as the previous one writes back
  assign in_stall  = !((state_r == ST_IDLE) || ((state_r == ST_MOD) && can_load));
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_accept) begin
        state_nxt = ST_CALC;
      end
      ST_CALC: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MOD;
      ST_MOD: if (can_load) begin
        state_nxt = in_accept ? ST_CALC : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- coordinate map
  rppp_map #(
    .WW (WW),
    .HW (HW),
    .LW (LW)
  ) u_map (
    .clk      (clk),
    .load     (in_accept),
    .calc     (state_r == ST_CALC),
    .req      (in_data),
    .rotation (rotation_r),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .lin      (lin),
    .ctl      (ctl)
  );

  // ---------------------------------------------------------------- frame store
  // eight pixels a byte in bit format, two in nibble format
  assign byte_addr = (format_r == rppp_pkg::FMT_NIB) ? (lin >> 1) : (lin >> 3);
  // pixels past the end of the store are neither read nor written
  assign hit       = ctl.ok && (32'(byte_addr) < 32'(STORE_BYTES));
  assign mem_re    = (state_r == ST_READ) && hit;
  // write-back lands before the next request reaches its read, so no bypass
  assign mem_we    = (state_r == ST_MOD) && can_load && hit && ctl.draw;

  rppp_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .re    (mem_re),
    .we    (mem_we),
    .addr  (AW'(byte_addr)),
    .wdata (wdata),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------- modify
  always_comb begin
    // leftmost pixel in the top bit, high nibble first
    bit_mask = rppp_pkg::BIT_MSB >> lin[2:0];
    nib_hi   = !lin[0];

    case (ctl.color)
      rppp_pkg::COL_BLACK: code = rppp_pkg::NIB_BLACK;
      rppp_pkg::COL_WHITE: code = rppp_pkg::NIB_WHITE;
      default:             code = rppp_pkg::NIB_RED;
    endcase

    if (format_r == rppp_pkg::FMT_NIB) begin
      if (nib_hi) begin
        wdata = (rdata & ~rppp_pkg::NIB_HI_MASK) | {code, 4'b0000};
      end else begin
        wdata = (rdata & rppp_pkg::NIB_HI_MASK) | {4'b0000, code};
      end
    end else if (ctl.color == rppp_pkg::COL_WHITE) begin
      wdata = rdata | bit_mask;
    end else begin
      // black, red and the unused colour code clear the bit
      wdata = rdata & ~bit_mask;
    end

    nib = (nib_hi ? 4'(rdata >> 4) : rdata[3:0]) & rppp_pkg::NIB_MASK;
    if (format_r == rppp_pkg::FMT_NIB) begin
      if (nib == rppp_pkg::NIB_BLACK) begin
        pix_color = rppp_pkg::COL_BLACK;
      end else if (nib == rppp_pkg::NIB_RED) begin
        pix_color = rppp_pkg::COL_RED;
      end else begin
        // unknown codes read as white
        pix_color = rppp_pkg::COL_WHITE;
      end
    end else begin
      pix_color = (|(rdata & bit_mask)) ? rppp_pkg::COL_WHITE : rppp_pkg::COL_BLACK;
    end

    // draws and misses report white
    res_nxt.read_color = (ctl.rd && hit) ? pix_color : rppp_pkg::COL_WHITE;
    res_nxt.in_range   = ctl.ok;
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_MOD) && can_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_MOD) && can_load) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- checks
  `RPPP_ASSERT_IMP(a_we_in_mod, mem_we, (state_r == ST_MOD) && hit && !mem_re)
  `RPPP_ASSERT_NXT(a_accept_calc, in_accept, state_r == ST_CALC)
  `RPPP_ASSERT_IMP(a_out_from_mod, $rose(out_valid_r), $past(state_r) == ST_MOD)

endmodule
